// ===== sv/greedy_text_line_justifier_core_defines.svh =====
// Assertion macros shared by the line justifier RTL.
`ifndef GREEDY_TEXT_LINE_JUSTIFIER_CORE_DEFINES_SVH
`define GREEDY_TEXT_LINE_JUSTIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define GTLJ_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("line justifier assertion failed");

// Next-cycle implication, checked outside of reset.
`define GTLJ_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("line justifier assertion failed");

`endif

// ===== sv/gtlj_pkg.sv =====
`default_nettype none
package gtlj_pkg;

    // Field widths.
    localparam int LEN_W   = 7;
    localparam int SPACE_W = 6;
    localparam int SUM_W   = 9;

    // Largest usable line width.
    localparam int WIDTH_MAX = 64;

    // Default buffer depth in words.
    localparam int LINE_WORDS_DEF = 32;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET = 7'd16;

    // Register index decoded from paddr[2].
    localparam logic REG_LINE_WIDTH = 1'b0;

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_JPREP  = 8'b0000_0100,
        ST_JDIV   = 8'b0000_1000,
        ST_JEMIT  = 8'b0001_0000,
        ST_APPEND = 8'b0010_0000,
        ST_LPREP  = 8'b0100_0000,
        ST_LEMIT  = 8'b1000_0000
    } state_t;

    // Clamp a space count to the output field.
    function automatic logic [SPACE_W-1:0] sat_spaces(input logic [LEN_W:0] sp);
        logic [SPACE_W-1:0] r;
        begin
            if (sp > (LEN_W+1)'({SPACE_W{1'b1}}))
            begin
                r = {SPACE_W{1'b1}};
            end
            else
            begin
                r = sp[SPACE_W-1:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/greedy_text_line_justifier_core.sv =====
// A word that closes no line passes the check and append states and yields no transaction.
// Closing a justified line adds a prepare state, then restoring divider steps when the free
// space covers the inner gaps, then one emit per buffered word; a final left-justified line
// adds a prepare state plus one emit per word. Throughput: one word at a time; a new word is
// stalled until the last one and any line it closes are emitted; emits wait on result_stall.
// Reset: control state clears, line_width returns to 16; buffer contents stay undefined.
`default_nettype none
`include "greedy_text_line_justifier_core_defines.svh"
module greedy_text_line_justifier_core #(
    parameter int LINE_WORDS = gtlj_pkg::LINE_WORDS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gtlj_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gtlj_pkg::DATA_W-1:0] pwdata,
    output logic      [gtlj_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // Word channel
    input  wire logic                        word_valid,
    output logic                             word_stall,
    input  wire logic [gtlj_pkg::LEN_W-1:0]  word_length,
    input  wire logic                        final_word,
    // Result channel
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [gtlj_pkg::LEN_W-1:0]  out_word_length,
    output logic      [gtlj_pkg::SPACE_W-1:0] spaces_after,
    output logic                             line_end,
    output logic                             left_justified_line,
    output logic                             run_last
);
    import gtlj_pkg::*;

    localparam int CW = $clog2(LINE_WORDS + 1);
    localparam int AW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int DIV_STEPS = LEN_W;
    localparam int DC_W = $clog2(DIV_STEPS);

    // Registers
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    line_width_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                fin_reg, fin_next;
    logic [CW-1:0]       words_reg, words_next;
    logic [LEN_W-1:0]    letters_reg, letters_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       gaps_reg, gaps_next;
    logic [LEN_W-1:0]    pad_reg, pad_next;
    logic [LEN_W-1:0]    quot_reg, quot_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [DC_W-1:0]     dcnt_reg, dcnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic [SPACE_W-1:0]  out_sp_reg, out_sp_next;
    logic                out_end_reg, out_end_next;
    logic                out_left_reg, out_left_next;
    logic                out_last_reg, out_last_next;

    // Line buffer
    logic [LEN_W-1:0]    line_word_lengths_mem [LINE_WORDS];
    logic [LEN_W-1:0]    rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;

    logic                cfg_write;
    logic                word_accept;
    logic                out_load;
    logic [LEN_W-1:0]    eff_w;
    logic [SUM_W-1:0]    fit_sum;
    logic [SUM_W-1:0]    used_sum;
    logic [LEN_W-1:0]    freesp;
    logic                last_word;
    logic [CW:0]         trial;
    logic                trial_ge;
    logic [LEN_W:0]      just_sp;

    // Configuration port: one register, writes decoded on paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LINE_WIDTH)
        begin
            prdata[LEN_W-1:0] = line_width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_LINE_WIDTH))
        begin
            line_width_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Effective width, clamped to 1..WIDTH_MAX.
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            eff_w = LEN_W'(1);
        end
        else if ({2'b00, line_width_reg} > SUM_W'(WIDTH_MAX))
        begin
            eff_w = LEN_W'(WIDTH_MAX);
        end
        else
        begin
            eff_w = line_width_reg;
        end
    end

    // Handshakes.
    assign word_stall  = (state_reg != ST_IDLE);
    assign word_accept = word_valid && !word_stall;
    assign out_load    = !out_valid_reg || !result_stall;

    // Shared arithmetic: fit test, free space, used width and one divider step.
    assign fit_sum  = SUM_W'(letters_reg) + SUM_W'(words_reg) + SUM_W'(len_reg);
    assign used_sum = SUM_W'(letters_reg) + SUM_W'(words_reg) - SUM_W'(1);
    assign freesp   = (eff_w > letters_reg) ? (eff_w - letters_reg) : '0;
    assign trial    = {rem_reg, quot_reg[LEN_W-1]};
    assign trial_ge = (trial >= {1'b0, gaps_reg});
    assign last_word = ((idx_reg + CW'(1)) == words_reg);

    // Justified spacing of the current word.
    always_comb
    begin
        if (words_reg == CW'(1))
        begin
            just_sp = {1'b0, pad_reg};
        end
        else if (idx_reg < gaps_reg)
        begin
            just_sp = {1'b0, quot_reg} + ((idx_reg < rem_reg) ? (LEN_W+1)'(1) : '0);
        end
        else
        begin
            just_sp = '0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        fin_next       = fin_reg;
        words_next     = words_reg;
        letters_next   = letters_reg;
        idx_next       = idx_reg;
        gaps_next      = gaps_reg;
        pad_next       = pad_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        out_len_next   = out_len_reg;
        out_sp_next    = out_sp_reg;
        out_end_next   = out_end_reg;
        out_left_next  = out_left_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (word_accept)
                begin
                    len_next   = word_length;
                    fin_next   = final_word;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((words_reg != '0) &&
                    ((words_reg >= CW'(LINE_WORDS)) || (fit_sum > SUM_W'(eff_w))))
                begin
                    state_next = ST_JPREP;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_JPREP:
            begin
                gaps_next = words_reg - CW'(1);
                pad_next  = freesp;
                rem_next  = '0;
                dcnt_next = '0;
                if (words_reg == CW'(1))
                begin
                    state_next = ST_JEMIT;
                end
                else if ({{(SUM_W-LEN_W){1'b0}}, freesp} < SUM_W'(words_reg - CW'(1)))
                begin
                    quot_next  = LEN_W'(1);
                    state_next = ST_JEMIT;
                end
                else
                begin
                    quot_next  = freesp;
                    state_next = ST_JDIV;
                end
            end
            ST_JDIV:
            begin
                // One restoring division step per cycle.
                quot_next = {quot_reg[LEN_W-2:0], trial_ge};
                rem_next  = trial_ge ? CW'(trial - {1'b0, gaps_reg}) : trial[CW-1:0];
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_JEMIT;
                end
            end
            ST_JEMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = rd_data_reg;
                    out_sp_next    = sat_spaces(just_sp);
                    out_end_next   = last_word;
                    out_left_next  = 1'b0;
                    out_last_next  = last_word && !fin_reg;
                    idx_next       = idx_reg + CW'(1);
                    if (last_word)
                    begin
                        words_next   = '0;
                        letters_next = '0;
                        idx_next     = '0;
                        state_next   = ST_APPEND;
                    end
                end
            end
            ST_APPEND:
            begin
                mem_we       = 1'b1;
                words_next   = words_reg + CW'(1);
                letters_next = letters_reg + len_reg;
                idx_next     = '0;
                state_next   = fin_reg ? ST_LPREP : ST_IDLE;
            end
            ST_LPREP:
            begin
                pad_next = (SUM_W'(eff_w) > used_sum) ? LEN_W'(SUM_W'(eff_w) - used_sum) : '0;
                state_next = ST_LEMIT;
            end
            ST_LEMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = rd_data_reg;
                    out_sp_next    = last_word ? sat_spaces({1'b0, pad_reg}) : SPACE_W'(1);
                    out_end_next   = last_word;
                    out_left_next  = 1'b1;
                    out_last_next  = last_word;
                    idx_next       = idx_reg + CW'(1);
                    if (last_word)
                    begin
                        words_next   = '0;
                        letters_next = '0;
                        idx_next     = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            words_reg     <= '0;
            letters_reg   <= '0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            letters_reg   <= letters_next;
            idx_reg       <= idx_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        fin_reg      <= fin_next;
        gaps_reg     <= gaps_next;
        pad_reg      <= pad_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        out_len_reg  <= out_len_next;
        out_sp_reg   <= out_sp_next;
        out_end_reg  <= out_end_next;
        out_left_reg <= out_left_next;
        out_last_reg <= out_last_next;
    end

    // Line buffer: one write port, one registered read port that prefetches the next word.
    assign rd_addr = idx_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_word_lengths_mem[words_reg[AW-1:0]] <= len_reg;
        end
        rd_data_reg <= line_word_lengths_mem[rd_addr];
    end

    // Result outputs.
    assign result_valid        = out_valid_reg;
    assign out_word_length     = out_len_reg;
    assign spaces_after        = out_sp_reg;
    assign line_end            = out_end_reg;
    assign left_justified_line = out_left_reg;
    assign run_last            = out_last_reg;

    // Checks.
    `GTLJ_ASSERT_IMP(a_words_bounded, clk, rst_n, 1'b1, words_reg <= CW'(LINE_WORDS))
    `GTLJ_ASSERT_IMP(a_emit_in_range, clk, rst_n,
        (state_reg == ST_JEMIT) || (state_reg == ST_LEMIT), idx_reg < words_reg)
    `GTLJ_ASSERT_IMP(a_div_rem_below, clk, rst_n, state_reg == ST_JDIV, rem_reg < gaps_reg)
    `GTLJ_ASSERT_NXT(a_accept_to_check, clk, rst_n, word_accept, state_reg == ST_CHECK)

endmodule
`default_nettype wire
